### rtl/ifmt_pkg.sv
// Shared types, constants and helper functions of the integer field formatter.
// Used by every module of the block but the checker; depends on nothing else.

package ifmt_pkg;

  // Field limits.
  localparam int MAX_FIELD   = 62;
  localparam int DIGIT_BUF   = 32;
  localparam int DIGIT_W     = 4;
  localparam int DIG_VEC_W   = DIGIT_BUF * DIGIT_W;
  localparam int LEN_W       = $clog2(DIGIT_BUF + 1);
  localparam int CNT_W       = 6;
  localparam int POS_W       = 7;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reciprocal of ten for an exact 32-bit quotient: q = (v * RECIP10) >> RECIP10_SH.
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;

  // ASCII codes.
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_X_LO  = 7'h78;
  localparam logic [6:0] CH_X_UP  = 7'h58;
  localparam logic [6:0] CH_A_LO  = 7'h61;
  localparam logic [6:0] CH_A_UP  = 7'h41;

  // Radix codes; unlisted codes act as decimal.
  typedef enum logic [2:0] {
    RADIX_DEC    = 3'd0,
    RADIX_HEX_LO = 3'd1,
    RADIX_HEX_UP = 3'd2,
    RADIX_OCT    = 3'd3,
    RADIX_BIN    = 3'd4
  } radix_t;

  // One formatted field as handed from the front to the back part.
  // Digits sit most significant first from the bottom nibble upwards.
  // The *_end values are character positions where each section stops.
  typedef struct packed {
    logic [DIG_VEC_W-1:0] digits;
    logic                 upper;
    logic [POS_W-1:0]     lead_end;
    logic [POS_W-1:0]     pre_end;
    logic [POS_W-1:0]     zero_end;
    logic [POS_W-1:0]     dig_end;
    logic [POS_W-1:0]     last_pos;
  } ifmt_job_t;

  // Saturate a signed length field at the maximum field size.
  function automatic logic signed [6:0] sat_len(input logic signed [6:0] raw);
    logic signed [6:0] lim;
    lim = 7'(MAX_FIELD);
    return (raw > lim) ? lim : raw;
  endfunction

  // ASCII character of one digit.
  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + 7'(d);
    end
    return base + 7'(d - 4'd10);
  endfunction

endpackage

### rtl/ifmt_front.sv
// Front part of the integer field formatter: takes a request, splits the value
// into digits one per cycle and works out the field layout. Uses ifmt_pkg.

module ifmt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [31:0]                value,
  input  logic [2:0]                 radix_mode,
  input  logic                       left_justify,
  input  logic                       hex_prefix,
  input  logic signed [6:0]          field_width,
  input  logic signed [6:0]          min_digits,
  output logic                       push,
  output ifmt_pkg::ifmt_job_t        push_job,
  input  logic                       queue_full
);
  import ifmt_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } fstate_t;

  fstate_t              state;
  radix_t               radix;
  logic [31:0]          val;
  logic [DIG_VEC_W-1:0] digits;
  logic [LEN_W-1:0]     len;
  logic                 upper;
  logic                 prefix;
  logic                 lj;
  logic signed [6:0]    fw;
  logic signed [6:0]    pw;

  // Digit extraction for the current value.
  logic [63:0]          prod;
  logic [31:0]          quot10;
  logic [31:0]          rem10;
  logic [DIGIT_W-1:0]   digit;
  logic [31:0]          val_next;
  logic [LEN_W-1:0]     len_next;
  logic                 conv_done;

  assign prod   = 64'(val) * 64'(RECIP10);
  assign quot10 = 32'(prod >> RECIP10_SH);
  assign rem10  = val - ((quot10 << 3) + (quot10 << 1));

  always_comb begin
    case (radix)
      RADIX_HEX_LO, RADIX_HEX_UP: begin
        digit    = val[3:0];
        val_next = val >> 4;
      end
      RADIX_OCT: begin
        digit    = {1'b0, val[2:0]};
        val_next = val >> 3;
      end
      RADIX_BIN: begin
        digit    = {3'b000, val[0]};
        val_next = val >> 1;
      end
      default: begin
        digit    = rem10[DIGIT_W-1:0];
        val_next = quot10;
      end
    endcase
  end

  assign len_next  = len + LEN_W'(1);
  assign conv_done = (val_next == '0) || (len_next == LEN_W'(DIGIT_BUF));

  // Field layout from the digit count, precision and width.
  logic signed [7:0] pw_s, fw_s, len_s, zeros_s, body_s, spaces_s;
  logic [POS_W-1:0]  spaces, lead_end, pre_end, zero_end, dig_end, total;

  always_comb begin
    pw_s     = 8'(pw);
    fw_s     = 8'(fw);
    len_s    = $signed(8'(len));
    zeros_s  = (pw_s > len_s) ? (pw_s - len_s) : '0;
    body_s   = zeros_s + len_s;
    spaces_s = ((pw_s < fw_s) && (fw_s > body_s)) ? (fw_s - body_s) : '0;
    spaces   = POS_W'(spaces_s[CNT_W-1:0]);
    lead_end = lj ? '0 : spaces;
    pre_end  = lead_end + (prefix ? POS_W'(2) : '0);
    zero_end = pre_end + POS_W'(zeros_s[CNT_W-1:0]);
    dig_end  = zero_end + POS_W'(len);
    total    = dig_end + (lj ? spaces : '0);
  end

  assign push_job.digits   = digits;
  assign push_job.upper    = upper;
  assign push_job.lead_end = lead_end;
  assign push_job.pre_end  = pre_end;
  assign push_job.zero_end = zero_end;
  assign push_job.dig_end  = dig_end;
  assign push_job.last_pos = total - POS_W'(1);

  assign push = (state == F_PUSH) && !queue_full;
  assign busy = (state != F_IDLE);

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            val    <= value;
            radix  <= radix_t'(radix_mode);
            upper  <= (radix_t'(radix_mode) == RADIX_HEX_UP);
            prefix <= hex_prefix && ((radix_t'(radix_mode) == RADIX_HEX_LO) ||
                                     (radix_t'(radix_mode) == RADIX_HEX_UP));
            lj     <= left_justify;
            fw     <= sat_len(field_width);
            pw     <= sat_len(min_digits);
            len    <= '0;
            state  <= F_CONV;
          end
        end
        F_CONV: begin
          digits <= {digits[DIG_VEC_W-DIGIT_W-1:0], digit};
          val    <= val_next;
          len    <= len_next;
          if (conv_done) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!queue_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ifmt_queue.sv
// Short queue of formatted jobs between the front and back parts.
// Uses ifmt_pkg for the job type and the depth.

module ifmt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ifmt_pkg::ifmt_job_t push_job,
  output logic                full,
  input  logic                pop,
  output ifmt_pkg::ifmt_job_t pop_job,
  output logic                empty
);
  import ifmt_pkg::*;

  ifmt_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Storage is written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/ifmt_back.sv
// Back part of the integer field formatter: emits the characters of each
// queued job, one per cycle, from registered outputs. Uses ifmt_pkg.

module ifmt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  ifmt_pkg::ifmt_job_t queue_job,
  output logic                pop,
  output logic                char_valid,
  output logic [6:0]          out_char,
  output logic                last_char
);
  import ifmt_pkg::*;

  ifmt_job_t        job;
  logic             active;
  logic [POS_W-1:0] pos;

  logic [6:0]       ch;
  logic             at_last;
  logic             in_digits;

  // Character at the current position.
  always_comb begin
    in_digits = 1'b0;
    if (pos < job.lead_end) begin
      ch = CH_SPACE;
    end else if (pos < job.pre_end) begin
      if (pos == job.lead_end) begin
        ch = CH_ZERO;
      end else begin
        ch = job.upper ? CH_X_UP : CH_X_LO;
      end
    end else if (pos < job.zero_end) begin
      ch = CH_ZERO;
    end else if (pos < job.dig_end) begin
      ch        = digit_char(job.digits[DIGIT_W-1:0], job.upper);
      in_digits = 1'b1;
    end else begin
      ch = CH_SPACE;
    end
  end

  assign at_last = (pos == job.last_pos);
  assign pop     = !queue_empty && (!active || at_last);

  // Job register, position counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      char_valid <= 1'b0;
      last_char  <= 1'b0;
    end else begin
      char_valid <= active;
      last_char  <= active && at_last;
      out_char   <= ch;
      if (pop) begin
        job    <= queue_job;
        pos    <= '0;
        active <= 1'b1;
      end else if (active) begin
        if (at_last) begin
          active <= 1'b0;
        end
        pos <= pos + POS_W'(1);
        if (in_digits) begin
          job.digits <= job.digits >> DIGIT_W;
        end
      end
    end
  end

endmodule

### rtl/integer_field_formatter.sv
// Integer field formatter: a request with start while busy is low formats a
// 32-bit value as a printf-style integer field and returns its characters one
// per cycle on out_char, each marked by char_valid for exactly one cycle, the
// final one also by last_char. The receiver cannot stall the output. After a
// request busy stays high while the value is split, one digit per cycle (up to
// 10 digits in decimal, 8 in hex, 11 in octal, 32 in binary, at least 1), and
// until the job is queued; no new request is taken before that. The characters
// follow from a two-job queue at one per cycle, up to 64 per field, so a long
// field ahead of later short ones holds busy high once the queue is full.

module integer_field_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       value,
  input  logic [2:0]        radix_mode,
  input  logic              left_justify,
  input  logic              hex_prefix,
  input  logic signed [6:0] field_width,
  input  logic signed [6:0] min_digits,
  output logic              char_valid,
  output logic [6:0]        out_char,
  output logic              last_char
);
  import ifmt_pkg::*;

  ifmt_job_t push_job;
  ifmt_job_t pop_job;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;

  // Digit split and layout.
  ifmt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .radix_mode   (radix_mode),
    .left_justify (left_justify),
    .hex_prefix   (hex_prefix),
    .field_width  (field_width),
    .min_digits   (min_digits),
    .push         (push),
    .push_job     (push_job),
    .queue_full   (queue_full)
  );

  // Decoupling queue.
  ifmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (queue_empty)
  );

  // Character emission.
  ifmt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_job   (pop_job),
    .pop         (pop),
    .char_valid  (char_valid),
    .out_char    (out_char),
    .last_char   (last_char)
  );

endmodule

### rtl/ifmt_checker.sv
// Port-level checks of the integer field formatter, bound to its top level.
// Depends only on the top level's ports.

module ifmt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              char_valid,
  input logic [6:0]        out_char,
  input logic              last_char
);

  // Reset leaves the block idle and silent.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !char_valid && !busy)
    else $error("output or busy active after reset");

  // An accepted request always raises busy in the cycle after it.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  // The end marker only comes with a character.
  a_last_with_char: assert property (@(posedge clk) disable iff (rst)
    last_char |-> char_valid)
    else $error("last_char without char_valid");

  // A field runs without gaps until its final character.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    char_valid && !last_char |=> char_valid)
    else $error("gap inside a field");

  // Every character is printable.
  a_printable: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (out_char >= 7'h20) && (out_char <= 7'h7E))
    else $error("non-printable character emitted");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .char_valid   (char_valid),
  .out_char     (out_char),
  .last_char    (last_char)
);
